FILE: rtl/bafr_pkg.sv
package bafr_pkg;

	localparam int MAX_WIDTH   = 2048;
	localparam int MAX_HEIGHT  = 2048;
	localparam int MAX_WINDOW  = 8;
	localparam int QUEUE_DEPTH = 2;

	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 12;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_IMAGE_WIDTH  = 2'd0,
		REG_IMAGE_HEIGHT = 2'd1,
		REG_WINDOW_SIZE  = 2'd2
	} reg_idx_t;

	localparam logic [11:0] RST_IMAGE_WIDTH  = 12'd640;
	localparam logic [11:0] RST_IMAGE_HEIGHT = 12'd480;
	localparam logic [3:0]  RST_WINDOW_SIZE  = 4'd3;

endpackage

FILE: rtl/bafr_if.sv
interface bafr_pix_if;
	logic       valid;
	logic       ready;
	logic       frame_start;
	logic [7:0] in_blue;
	logic [7:0] in_green;
	logic [7:0] in_red;

	modport source(output valid, output frame_start, output in_blue, output in_green,
		output in_red, input ready);
	modport sink(input valid, input frame_start, input in_blue, input in_green,
		input in_red, output ready);
endinterface

interface bafr_res_if;
	logic        valid;
	logic        ready;
	logic        out_valid;
	logic [10:0] out_row;
	logic [10:0] out_col;
	logic [7:0]  out_blue;
	logic [7:0]  out_green;
	logic [7:0]  out_red;

	modport source(output valid, output out_valid, output out_row, output out_col,
		output out_blue, output out_green, output out_red, input ready);
	modport sink(input valid, input out_valid, input out_row, input out_col,
		input out_blue, input out_green, input out_red, output ready);
endinterface

FILE: rtl/bafr_ram.sv
module bafr_ram #(
	parameter int WIDTH = 24,
	parameter int DEPTH = 16384
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

FILE: rtl/bafr_fifo.sv
module bafr_fifo #(
	parameter int W     = 8,
	parameter int DEPTH = 2
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         push,
	input  logic [W-1:0] wdata,
	output logic         full,
	input  logic         pop,
	output logic [W-1:0] rdata,
	output logic         nempty
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	logic [W-1:0]  buf_q [DEPTH];
	logic [PW-1:0] wp_q, rp_q;
	logic [PW:0]   cnt_q;

	assign full   = (cnt_q == (PW+1)'(DEPTH));
	assign nempty = (cnt_q != '0);
	assign rdata  = buf_q[rp_q];

	always_ff @(posedge clk) begin
		if (push) begin
			buf_q[wp_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wp_q <= (wp_q == PW'(DEPTH - 1)) ? '0 : wp_q + 1'b1;
			end
			if (pop) begin
				rp_q <= (rp_q == PW'(DEPTH - 1)) ? '0 : rp_q + 1'b1;
			end
			cnt_q <= cnt_q + (PW+1)'(push) - (PW+1)'(pop);
		end
	end

endmodule

FILE: rtl/bafr_front.sv
module bafr_front #(
	parameter int MAX_WIDTH  = bafr_pkg::MAX_WIDTH,
	parameter int MAX_HEIGHT = bafr_pkg::MAX_HEIGHT,
	parameter int MAX_WINDOW = bafr_pkg::MAX_WINDOW,
	localparam int CW  = $clog2(MAX_WIDTH),
	localparam int RW  = $clog2(MAX_HEIGHT),
	localparam int SLW = $clog2(MAX_WINDOW),
	localparam int RRW = $clog2(MAX_WINDOW + 1),
	localparam int EW  = 24 + CW + SLW + SLW + RRW + 1 + 11 + 11
) (
	input  logic          clk,
	input  logic          arst_n,
	bafr_pix_if.sink      pix,
	input  logic [11:0]   image_width,
	input  logic [11:0]   image_height,
	input  logic [3:0]    window_size,
	output logic          push,
	output logic [EW-1:0] entry,
	input  logic          full
);

	localparam int XW = $clog2(MAX_WIDTH + 1);
	localparam int YW = $clog2(MAX_HEIGHT + 1);

	logic [CW-1:0]  col_q, col_c;
	logic [RW-1:0]  row_q, row_c;
	logic [SLW-1:0] slot_q, slot_c;
	logic [XW-1:0]  w;
	logic [YW-1:0]  h;
	logic [RRW-1:0] r;
	logic [SLW-1:0] n;
	logic           ok;
	logic [10:0]    orow, ocol;

	always_comb begin
		w = (image_width == '0) ? XW'(1) :
			(32'(image_width) > MAX_WIDTH) ? XW'(MAX_WIDTH) : XW'(image_width);
		h = (image_height == '0) ? YW'(1) :
			(32'(image_height) > MAX_HEIGHT) ? YW'(MAX_HEIGHT) : YW'(image_height);
		r = (window_size == '0) ? RRW'(1) :
			(32'(window_size) > MAX_WINDOW) ? RRW'(MAX_WINDOW) : RRW'(window_size);

		col_c  = pix.frame_start ? '0 : col_q;
		row_c  = pix.frame_start ? '0 : row_q;
		slot_c = pix.frame_start ? '0 : slot_q;

		ok = (32'(row_c) + 32'd1 >= 32'(r)) && (32'(col_c) + 32'd1 >= 32'(r)) &&
			(32'(row_c) + 32'd1 < 32'(h)) && (32'(col_c) + 32'd1 < 32'(w));
		orow = ok ? 11'(32'(row_c) + 32'd1 - 32'(r)) : '0;
		ocol = ok ? 11'(32'(col_c) + 32'd1 - 32'(r)) : '0;
		// rows above the current one that feed the vertical sum
		n = (32'(row_c) < 32'(r) - 32'd1) ? SLW'(row_c) : SLW'(r - 1'b1);
	end

	assign pix.ready = !full;
	assign push      = pix.valid && !full;
	assign entry     = {pix.in_red, pix.in_green, pix.in_blue, col_c, slot_c, n, r, ok,
		orow, ocol};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q  <= '0;
			row_q  <= '0;
			slot_q <= '0;
		end else if (push) begin
			if (32'(col_c) + 32'd1 >= 32'(w)) begin
				col_q <= '0;
				if (32'(row_c) + 32'd1 < MAX_HEIGHT) begin
					row_q  <= row_c + 1'b1;
					slot_q <= (slot_c == SLW'(MAX_WINDOW - 1)) ? '0 : slot_c + 1'b1;
				end else begin
					row_q  <= row_c;
					slot_q <= slot_c;
				end
			end else begin
				col_q  <= col_c + 1'b1;
				row_q  <= row_c;
				slot_q <= slot_c;
			end
		end
	end

endmodule

FILE: rtl/bafr_back.sv
module bafr_back #(
	parameter int MAX_WIDTH  = bafr_pkg::MAX_WIDTH,
	parameter int MAX_WINDOW = bafr_pkg::MAX_WINDOW,
	localparam int CW  = $clog2(MAX_WIDTH),
	localparam int SLW = $clog2(MAX_WINDOW),
	localparam int RRW = $clog2(MAX_WINDOW + 1),
	localparam int EW  = 24 + CW + SLW + SLW + RRW + 1 + 11 + 11
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic [EW-1:0] entry,
	input  logic          nempty,
	output logic          pop,
	bafr_res_if.source    res
);

	localparam int VW  = $clog2(MAX_WINDOW * 255 + 1);
	localparam int WSW = $clog2(MAX_WINDOW * MAX_WINDOW * 255 + 1);
	localparam int DW  = $clog2(MAX_WINDOW * MAX_WINDOW + 1);
	localparam int KW  = $clog2(WSW + 1);

	typedef enum logic [5:0] {
		S_IDLE = 6'b000001,
		S_RD   = 6'b000010,
		S_ACC  = 6'b000100,
		S_SUM  = 6'b001000,
		S_DIV  = 6'b010000,
		S_OUT  = 6'b100000
	} state_t;

	state_t state_q;

	logic [23:0]    e_pix;
	logic [CW-1:0]  e_col;
	logic [SLW-1:0] e_slot, e_n;
	logic [RRW-1:0] e_r;
	logic           e_ok;
	logic [10:0]    e_orow, e_ocol;

	assign {e_pix, e_col, e_slot, e_n, e_r, e_ok, e_orow, e_ocol} = entry;

	logic [CW-1:0]  col_q;
	logic [SLW-1:0] rslot_q, n_q, k_q;
	logic [RRW-1:0] r_q;
	logic           ok_q;
	logic [10:0]    orow_q, ocol_q;
	logic [DW-1:0]  d_q;
	logic [KW-1:0]  dcnt_q;

	logic [VW-1:0]  vsum_q [3];
	logic [VW-1:0]  hist_q [MAX_WINDOW-1][3];
	logic [WSW-1:0] dvd_q  [3];
	logic [DW-1:0]  rem_q  [3];
	logic [WSW-1:0] wsum_c [3];
	logic [DW:0]    remn_c [3];

	logic [23:0]    rdata;

	logic        ovalid_q;
	logic        ok_out_q;
	logic [10:0] orow_o_q, ocol_o_q;
	logic [7:0]  ob_q, og_q, or_q;
	logic        load_out;

	assign pop      = (state_q == S_IDLE) && nempty;
	assign load_out = (state_q == S_OUT) && (!ovalid_q || res.ready);

	bafr_ram #(.WIDTH(24), .DEPTH(MAX_WINDOW * (2 ** CW))) u_line (
		.clk  (clk),
		.we   (pop),
		.waddr({e_slot, e_col}),
		.wdata(e_pix),
		.raddr({rslot_q, col_q}),
		.rdata(rdata)
	);

	// window sum: this column's vertical sum plus the newest R-1 older ones
	always_comb begin
		for (int c = 0; c < 3; c++) begin
			wsum_c[c] = WSW'(vsum_q[c]);
			for (int j = 0; j < MAX_WINDOW - 1; j++) begin
				if (32'(j) + 32'd1 < 32'(r_q)) begin
					wsum_c[c] = wsum_c[c] + WSW'(hist_q[j][c]);
				end
			end
			remn_c[c] = {rem_q[c], dvd_q[c][WSW-1]};
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				col_q   <= e_col;
				n_q     <= e_n;
				r_q     <= e_r;
				ok_q    <= e_ok;
				orow_q  <= e_orow;
				ocol_q  <= e_ocol;
				d_q     <= DW'(e_r) * DW'(e_r);
				k_q     <= SLW'(1);
				rslot_q <= (e_slot == '0) ? SLW'(MAX_WINDOW - 1) : e_slot - 1'b1;
				for (int c = 0; c < 3; c++) begin
					vsum_q[c] <= VW'(e_pix[8*c +: 8]);
				end
			end
			S_ACC: begin
				for (int c = 0; c < 3; c++) begin
					vsum_q[c] <= vsum_q[c] + VW'(rdata[8*c +: 8]);
				end
				k_q     <= k_q + 1'b1;
				rslot_q <= (rslot_q == '0) ? SLW'(MAX_WINDOW - 1) : rslot_q - 1'b1;
			end
			S_SUM: begin
				dcnt_q <= '0;
				for (int c = 0; c < 3; c++) begin
					dvd_q[c] <= wsum_c[c];
					rem_q[c] <= '0;
				end
			end
			S_DIV: begin
				dcnt_q <= dcnt_q + 1'b1;
				for (int c = 0; c < 3; c++) begin
					if (remn_c[c] >= (DW+1)'(d_q)) begin
						rem_q[c] <= DW'(remn_c[c] - (DW+1)'(d_q));
						dvd_q[c] <= {dvd_q[c][WSW-2:0], 1'b1};
					end else begin
						rem_q[c] <= DW'(remn_c[c]);
						dvd_q[c] <= {dvd_q[c][WSW-2:0], 1'b0};
					end
				end
			end
			default: begin
			end
		endcase
		if (load_out) begin
			orow_o_q <= orow_q;
			ocol_o_q <= ocol_q;
			ob_q     <= ok_q ? dvd_q[0][7:0] : '0;
			og_q     <= ok_q ? dvd_q[1][7:0] : '0;
			or_q     <= ok_q ? dvd_q[2][7:0] : '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			ovalid_q <= 1'b0;
			for (int j = 0; j < MAX_WINDOW - 1; j++) begin
				for (int c = 0; c < 3; c++) begin
					hist_q[j][c] <= '0;
				end
			end
		end else begin
			if (load_out) begin
				ovalid_q <= 1'b1;
			end else if (res.ready) begin
				ovalid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (nempty) begin
						state_q <= (e_n == '0) ? S_SUM : S_RD;
					end
				end
				S_RD: state_q <= S_ACC;
				S_ACC: state_q <= (k_q == n_q) ? S_SUM : S_RD;
				S_SUM: begin
					for (int j = MAX_WINDOW - 2; j > 0; j--) begin
						for (int c = 0; c < 3; c++) begin
							hist_q[j][c] <= hist_q[j-1][c];
						end
					end
					for (int c = 0; c < 3; c++) begin
						hist_q[0][c] <= vsum_q[c];
					end
					state_q <= ok_q ? S_DIV : S_OUT;
				end
				S_DIV: begin
					if (dcnt_q == KW'(WSW - 1)) begin
						state_q <= S_OUT;
					end
				end
				S_OUT: begin
					if (load_out) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			ok_out_q <= ok_q;
		end
	end

	assign res.valid     = ovalid_q;
	assign res.out_valid = ok_out_q;
	assign res.out_row   = orow_o_q;
	assign res.out_col   = ocol_o_q;
	assign res.out_blue  = ob_q;
	assign res.out_green = og_q;
	assign res.out_red   = or_q;

endmodule

FILE: rtl/box_average_filter_rgb.sv
// channel | dir | handshake      | item
// pix     | in  | valid / ready  | frame_start, in_blue, in_green, in_red
// res     | out | valid / ready  | out_valid, out_row, out_col, out_blue/green/red
// cfg     | in  | cfg_we         | cfg_index, cfg_data (no read-back)
//
// The back end takes an item through idle, a read and an accumulate step per older
// row (min(R-1, row) of them), a sum step, bit-serial division of the 14-bit window
// sum by R*R for a valid window only, and output. The line store has one read port.
// Reset clears position counters, column sum history and handshake state, not the
// line store. A two-item queue lets the front take pixels while results stall.
module box_average_filter_rgb #(
	parameter int MAX_WIDTH  = bafr_pkg::MAX_WIDTH,
	parameter int MAX_HEIGHT = bafr_pkg::MAX_HEIGHT,
	parameter int MAX_WINDOW = bafr_pkg::MAX_WINDOW
) (
	input  logic                            clk,
	input  logic                            arst_n,
	bafr_pix_if.sink                        pix,
	bafr_res_if.source                      res,
	input  logic                            cfg_we,
	input  logic [bafr_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [bafr_pkg::CFG_DATA_W-1:0] cfg_data
);

	localparam int CW  = $clog2(MAX_WIDTH);
	localparam int SLW = $clog2(MAX_WINDOW);
	localparam int RRW = $clog2(MAX_WINDOW + 1);
	localparam int EW  = 24 + CW + SLW + SLW + RRW + 1 + 11 + 11;

	logic [11:0] width_q, height_q;
	logic [3:0]  wsize_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= bafr_pkg::RST_IMAGE_WIDTH;
			height_q <= bafr_pkg::RST_IMAGE_HEIGHT;
			wsize_q  <= bafr_pkg::RST_WINDOW_SIZE;
		end else if (cfg_we) begin
			case (cfg_index)
				bafr_pkg::REG_IMAGE_WIDTH:  width_q  <= cfg_data;
				bafr_pkg::REG_IMAGE_HEIGHT: height_q <= cfg_data;
				bafr_pkg::REG_WINDOW_SIZE:  wsize_q  <= cfg_data[3:0];
				default: begin
				end
			endcase
		end
	end

	logic          push, full, pop, nempty;
	logic [EW-1:0] wentry, rentry;

	bafr_front #(
		.MAX_WIDTH (MAX_WIDTH),
		.MAX_HEIGHT(MAX_HEIGHT),
		.MAX_WINDOW(MAX_WINDOW)
	) u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.pix         (pix),
		.image_width (width_q),
		.image_height(height_q),
		.window_size (wsize_q),
		.push        (push),
		.entry       (wentry),
		.full        (full)
	);

	bafr_fifo #(.W(EW), .DEPTH(bafr_pkg::QUEUE_DEPTH)) u_queue (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (push),
		.wdata (wentry),
		.full  (full),
		.pop   (pop),
		.rdata (rentry),
		.nempty(nempty)
	);

	bafr_back #(
		.MAX_WIDTH (MAX_WIDTH),
		.MAX_WINDOW(MAX_WINDOW)
	) u_back (
		.clk   (clk),
		.arst_n(arst_n),
		.entry (rentry),
		.nempty(nempty),
		.pop   (pop),
		.res   (res)
	);

endmodule
